### rtl/glos_pkg.sv
// glos_pkg: shared types and constants of the grid line-of-sight check block
// used by glos_ctrl, glos_dp and grid_line_of_sight_check_core
`timescale 1ns / 1ps
package glos_pkg;

  localparam int COORD_W = 10;
  localparam int FRAC_W  = 16;
  localparam int NUM_W   = COORD_W + FRAC_W;
  localparam int POS_W   = NUM_W + 1;
  localparam int DIST_W  = FRAC_W + 1;
  localparam int SQ_W    = 2 * DIST_W;

  typedef struct packed {
    logic       load;
    logic       ram_write;
    logic       div_init;
    logic       div_step;
    logic       advance;
    logic       issue;
    logic [1:0] sub;
  } glos_cmd_t;

  typedef struct packed {
    logic clear;
  } glos_sts_t;

endpackage

### rtl/glos_ram.sv
// glos_ram: generic single-port ram with registered read
// no dependencies
`timescale 1ns / 1ps
module glos_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1048576
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

### rtl/glos_ctrl.sv
// glos_ctrl: sequencer for write and segment check requests, output register
// depends on glos_pkg
`timescale 1ns / 1ps
module glos_ctrl #(
  parameter int SAMPLES = 200
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               command,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               path_clear,
  output glos_pkg::glos_cmd_t cmd,
  input  glos_pkg::glos_sts_t sts
);

  localparam int NCAND    = 4 * SAMPLES;
  localparam int CW       = $clog2(NCAND + 1);
  localparam int DIV_LAST = 2;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_WRITE = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_STEP  = 3'd3;
  localparam logic [2:0] ST_RUN   = 3'd4;
  localparam logic [2:0] ST_DRAIN = 3'd5;
  localparam logic [2:0] ST_DONE  = 3'd6;

  logic [2:0]    state, state_next;
  logic [CW-1:0] cnt, cnt_next;
  logic          out_free;

  assign in_stall = (state != ST_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    cmd.sub    = cnt[1:0];
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          cnt_next = '0;
          state_next = command ? ST_DIV : ST_WRITE;
        end
      end
      ST_WRITE: begin
        cmd.ram_write = 1'b1;
        state_next = ST_DONE;
      end
      ST_DIV: begin
        if (cnt == '0) begin
          cmd.div_init = 1'b1;
          cnt_next = cnt + 1'b1;
        end else begin
          cmd.div_step = 1'b1;
          if (cnt == CW'(DIV_LAST)) begin
            cnt_next = '0;
            state_next = ST_STEP;
          end else begin
            cnt_next = cnt + 1'b1;
          end
        end
      end
      ST_STEP: begin
        cmd.advance = 1'b1;
        cnt_next = '0;
        state_next = ST_RUN;
      end
      ST_RUN: begin
        cmd.issue = 1'b1;
        if (cnt == CW'(NCAND - 1)) begin
          cnt_next = '0;
          state_next = ST_DRAIN;
        end else begin
          cmd.advance = (cnt[1:0] == 2'd3);
          cnt_next = cnt + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (cnt == CW'(2)) begin
          state_next = ST_DONE;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      path_clear <= sts.clear;
    end
  end

endmodule

### rtl/glos_dp.sv
// glos_dp: occupancy map, sample stepping, candidate pipeline and blocked flag
// depends on glos_pkg and glos_ram
`timescale 1ns / 1ps
module glos_dp #(
  parameter int MAP_ROWS = 1024,
  parameter int MAP_COLS = 1024,
  parameter int SAMPLES  = 200
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                command,
  input  logic [9:0]          row_a,
  input  logic [9:0]          col_a,
  input  logic [9:0]          row_b,
  input  logic [9:0]          col_b,
  input  logic                cell_blocked,
  input  glos_pkg::glos_cmd_t cmd,
  output glos_pkg::glos_sts_t sts
);

  localparam int DEPTH = MAP_ROWS * MAP_COLS;
  localparam int AW    = $clog2(DEPTH);
  localparam int SW    = $clog2(SAMPLES + 1);
  localparam int NW    = glos_pkg::NUM_W;
  localparam int PW    = glos_pkg::POS_W;
  localparam int FW    = glos_pkg::FRAC_W;
  localparam int DW    = glos_pkg::DIST_W;
  localparam int QW    = glos_pkg::SQ_W;
  localparam int IW    = 13;
  localparam int LS    = $clog2(SAMPLES);
  localparam int SH    = NW + LS;
  localparam int MW    = NW + 1;
  localparam logic [MW-1:0] RECIP =
    MW'(((64'd1 << SH) + 64'(SAMPLES) - 64'd1) / 64'(SAMPLES));

  logic          cmd_r, blk_r;
  logic [9:0]    ra, ca, rb, cb;
  logic          swap;
  logic [9:0]    rs, cs, re, ce, cmin, cmax, dr_mag, dc_mag;
  logic          dc_neg;

  logic [NW-1:0]    num [2];
  logic [NW+MW-1:0] prod [2];
  logic [NW-1:0]    qs [2];
  logic [NW-1:0]    dq [2];
  logic [SW:0]      drem [2];
  logic [NW-1:0]    qacc [2];
  logic [SW:0]      racc [2];
  logic [SW+1:0]    rsum [2];
  logic [NW-1:0]    nmag [2];

  logic [PW-1:0] pr, pc;
  logic [IW-1:0] ci, cj;
  logic [DW-1:0] dr, dc;
  logic          cvalid;

  logic [DW-1:0] s1_dr, s1_dc;
  logic          s1_v;
  logic [QW-1:0] s2_sr, s2_sc;
  logic          s2_v, s2_occ;
  logic          blocked;
  logic [QW:0]   dsum;

  logic [IW-1:0] a_row, a_col;
  logic [AW-1:0] addr;
  logic          we, wr_ok, rdata;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r <= command;
      ra    <= row_a;
      ca    <= col_a;
      rb    <= row_b;
      cb    <= col_b;
      blk_r <= cell_blocked;
    end
  end

  always_comb begin
    swap   = !((ra < rb) || ((ra == rb) && (ca <= cb)));
    rs     = swap ? rb : ra;
    cs     = swap ? cb : ca;
    re     = swap ? ra : rb;
    ce     = swap ? ca : cb;
    dc_neg = (ce < cs);
    cmin   = dc_neg ? ce : cs;
    cmax   = dc_neg ? cs : ce;
    dr_mag = re - rs;
    dc_mag = cmax - cmin;
    nmag[0] = {dr_mag, {FW{1'b0}}};
    nmag[1] = {dc_mag, {FW{1'b0}}};
  end

  // reciprocal division of each axis step by the sample count
  for (genvar a = 0; a < 2; a++) begin : g_axis
    assign prod[a] = (NW + MW)'(num[a]) * (NW + MW)'(RECIP);
    assign qs[a]   = dq[a] * NW'(SAMPLES);
    assign rsum[a] = {1'b0, racc[a]} + {1'b0, drem[a]};

    always_ff @(posedge clk) begin
      if (cmd.div_init) begin
        num[a]  <= nmag[a];
        qacc[a] <= '0;
        racc[a] <= (SW + 1)'(SAMPLES / 2);
      end else if (cmd.div_step) begin
        dq[a]   <= NW'(prod[a] >> SH);
        drem[a] <= (SW + 1)'(num[a] - qs[a]);
      end else if (cmd.advance) begin
        if (rsum[a] >= (SW + 2)'(SAMPLES)) begin
          racc[a] <= (SW + 1)'(rsum[a] - (SW + 2)'(SAMPLES));
          qacc[a] <= qacc[a] + dq[a] + 1'b1;
        end else begin
          racc[a] <= rsum[a][SW:0];
          qacc[a] <= qacc[a] + dq[a];
        end
      end
    end
  end

  always_comb begin
    pr = {1'b0, rs, {FW{1'b0}}} + {1'b0, qacc[0]};
    pc = dc_neg ? ({1'b0, cs, {FW{1'b0}}} - {1'b0, qacc[1]})
                : ({1'b0, cs, {FW{1'b0}}} + {1'b0, qacc[1]});
    ci = IW'(pr[PW-1:FW]) + IW'(cmd.sub[1]);
    cj = IW'(pc[PW-1:FW]) + IW'(cmd.sub[0]);
    dr = cmd.sub[1] ? (DW'(1) << FW) - DW'(pr[FW-1:0]) : DW'(pr[FW-1:0]);
    dc = cmd.sub[0] ? (DW'(1) << FW) - DW'(pc[FW-1:0]) : DW'(pc[FW-1:0]);
    cvalid = (ci >= IW'(rs)) && (ci <= IW'(re)) && (cj >= IW'(cmin)) &&
             (cj <= IW'(cmax)) && (ci < IW'(MAP_ROWS)) && (cj < IW'(MAP_COLS));
  end

  assign wr_ok = (IW'(ra) < IW'(MAP_ROWS)) && (IW'(ca) < IW'(MAP_COLS));
  assign we    = cmd.ram_write && wr_ok;
  assign a_row = cmd.ram_write ? IW'(ra) : ci;
  assign a_col = cmd.ram_write ? IW'(ca) : cj;
  assign addr  = AW'(a_row) * AW'(MAP_COLS) + AW'(a_col);

  glos_ram #(
    .WIDTH(1),
    .DEPTH(DEPTH)
  ) u_map (
    .clk  (clk),
    .we   (we),
    .addr (addr),
    .wdata(blk_r),
    .rdata(rdata)
  );

  assign dsum = {1'b0, s2_sr} + {1'b0, s2_sc};

  always_ff @(posedge clk) begin
    s1_dr  <= dr;
    s1_dc  <= dc;
    s2_sr  <= s1_dr * s1_dr;
    s2_sc  <= s1_dc * s1_dc;
    s2_occ <= rdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v    <= 1'b0;
      s2_v    <= 1'b0;
      blocked <= 1'b0;
    end else begin
      s1_v <= cmd.issue && cvalid;
      s2_v <= s1_v;
      if (cmd.load) begin
        blocked <= 1'b0;
      end else if (s2_v && s2_occ && (dsum < ((QW + 1)'(1) << (2 * FW)))) begin
        blocked <= 1'b1;
      end
    end
  end

  assign sts.clear = cmd_r ? !blocked : 1'b1;

endmodule

### rtl/grid_line_of_sight_check_core.sv
// grid_line_of_sight_check_core: top level of the occupancy grid line-of-sight check
// depends on glos_pkg, glos_ctrl, glos_dp, glos_ram
//
// usage:
//   input channel in_valid/in_stall carries one request: command 0 writes
//   cell_blocked into the map cell (row_a, col_a), command 1 checks the
//   segment between (row_a, col_a) and (row_b, col_b)
//   output channel out_valid/out_stall returns path_clear, one per request,
//   1 after a write, 1 for a clear segment, 0 when an occupied cell is crossed
// sequence:
//   write: the map cell is written, then path_clear is registered
//   check: a reciprocal division of each axis step by SAMPLES, then the map
//   read port visits four neighbor cells of each sample, one per cycle, then
//   the candidate pipeline drains and path_clear is registered
//   one request at a time; the next is accepted while the result waits
// reset: control returns to idle and the output empties; the map keeps
//   its contents and cells must be written before they are checked
// stall: a held result keeps its value; a finished request waits for the
//   output register before the block takes the next one
`timescale 1ns / 1ps
module grid_line_of_sight_check_core #(
  parameter int MAP_ROWS = 1024,
  parameter int MAP_COLS = 1024,
  parameter int SAMPLES  = 200
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       command,
  input  logic [9:0] row_a,
  input  logic [9:0] col_a,
  input  logic [9:0] row_b,
  input  logic [9:0] col_b,
  input  logic       cell_blocked,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       path_clear
);

  glos_pkg::glos_cmd_t cmd;
  glos_pkg::glos_sts_t sts;

  glos_ctrl #(
    .SAMPLES(SAMPLES)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .command   (command),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .path_clear(path_clear),
    .cmd       (cmd),
    .sts       (sts)
  );

  glos_dp #(
    .MAP_ROWS(MAP_ROWS),
    .MAP_COLS(MAP_COLS),
    .SAMPLES (SAMPLES)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .command     (command),
    .row_a       (row_a),
    .col_a       (col_a),
    .row_b       (row_b),
    .col_b       (col_b),
    .cell_blocked(cell_blocked),
    .cmd         (cmd),
    .sts         (sts)
  );

`ifndef NO_ASSERTIONS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("block took a request without going busy");

  a_write_not_issue: assert property (@(posedge clk) disable iff (rst)
    cmd.ram_write |-> !(cmd.issue || cmd.div_step || cmd.advance))
    else $error("map write overlaps a check");

  a_issue_only_busy: assert property (@(posedge clk) disable iff (rst)
    (cmd.issue || cmd.ram_write) |-> in_stall)
    else $error("datapath active while idle");
`endif

endmodule
